>>> src/ecd_pkg.sv
// Shared types and constants for the escape sequence decoder.
`timescale 1ns / 1ps
`default_nettype none

package ecd_pkg;

    localparam int CHAR_W      = 8;
    localparam int QUEUE_DEPTH = 4;

    // Decoded results of one input word: up to two bytes, then an optional terminator.
    typedef struct packed {
        logic [1:0]        cnt;
        logic [CHAR_W-1:0] ch0;
        logic [CHAR_W-1:0] ch1;
        logic              term;
    } rec_t;

endpackage

`default_nettype wire

>>> src/escape_sequence_decoder_top.sv
// Top level of the escape sequence decoder: front end, record queue, output serializer.
//
//  channel  dir  tdata (low bit up)   tlast
//  s_axis   in   [7:0] raw character  last character of the string
//  m_axis   out  [7:0] decoded byte   terminator word closing the string
//
// One input word is taken every cycle while the record queue has room.
// Each input word yields zero to three output words; the serializer sends one
// per cycle unless m_axis stalls, so a burst of three holds the input back
// only once the queue fills. Each result passes the record queue and output register.
// aresetn is synchronous and clears all control state; both sides may stall freely.
`timescale 1ns / 1ps
`default_nettype none

module escape_sequence_decoder_top #(
    parameter int QUEUE_DEPTH = ecd_pkg::QUEUE_DEPTH
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [ecd_pkg::CHAR_W-1:0]  s_axis_tdata,   // [7:0] in_char
    input  wire logic                        s_axis_tlast,   // in_last
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic [ecd_pkg::CHAR_W-1:0]       m_axis_tdata,   // [7:0] out_char
    output logic                             m_axis_tlast    // out_end
);
    import ecd_pkg::*;

    localparam int LVL_W = $clog2(QUEUE_DEPTH+1);

    logic             in_fire;
    logic             push;
    rec_t             push_rec;
    logic             pop;
    logic             head_valid;
    rec_t             head_rec;
    logic             q_full;
    logic [LVL_W-1:0] q_level;

    assign s_axis_tready = !q_full;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    ecd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .in_char  (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .push     (push),
        .push_rec (push_rec)
    );

    ecd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_rec   (push_rec),
        .pop        (pop),
        .head_valid (head_valid),
        .head_rec   (head_rec),
        .full       (q_full),
        .level      (q_level)
    );

    ecd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (head_valid),
        .head_rec      (head_rec),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_level <= LVL_W'(QUEUE_DEPTH))
        else $error("record queue level above depth");

    a_ready_when_room: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> q_level == LVL_W'(QUEUE_DEPTH))
        else $error("input stalled while queue has room");

    a_term_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == '0)
        else $error("terminator word carries nonzero data");

    a_pop_has_head: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("record popped from empty queue");

endmodule

`default_nettype wire

>>> src/ecd_front.sv
// Front end: escape sequence state machine, one input word per cycle while in_fire is high, into a result record.
`timescale 1ns / 1ps
`default_nettype none

module ecd_front (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      in_fire,
    input  wire logic [ecd_pkg::CHAR_W-1:0] in_char,
    input  wire logic                      in_last,
    output logic                           push,
    output ecd_pkg::rec_t                  push_rec
);
    import ecd_pkg::*;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_BSL   = 3'd1;
    localparam logic [2:0] PH_CARET = 3'd2;
    localparam logic [2:0] PH_HEX   = 3'd3;
    localparam logic [2:0] PH_OCT   = 3'd4;
    localparam logic [2:0] PH_DEC   = 3'd5;

    localparam int ACC_W = 10;

    localparam logic [CHAR_W-1:0] CH_BSL   = 8'h5c;
    localparam logic [CHAR_W-1:0] CH_CARET = 8'h5e;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] META_BIT = 8'h80;
    localparam logic [CHAR_W-1:0] CTRL_MASK = 8'h1f;

    logic [2:0]       phase_reg, phase_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [1:0]       ds_reg, ds_next;
    logic             meta_reg, meta_next;

    logic [4:0]        dig;
    logic              dig_ok;
    logic [ACC_W-1:0]  acc_sum;
    logic [ACC_W+3:0]  dec_sum;
    logic [1:0]        ds_inc;
    logic              dig_full;
    logic [CHAR_W-1:0] esc_val;
    logic              numeric_next;

    // digit value of a character, 16 when it is no hex digit
    function automatic logic [4:0] digit_of(input logic [CHAR_W-1:0] c);
        logic [4:0] v;
        v = 5'd16;
        if (c >= CH_ZERO && c <= 8'h39) begin
            v = 5'(c - CH_ZERO);
        end else if (c >= CH_LO_A && c <= 8'h66) begin
            v = 5'(c - CH_LO_A) + 5'd10;
        end else if (c >= CH_UP_A && c <= 8'h46) begin
            v = 5'(c - CH_UP_A) + 5'd10;
        end
        return v;
    endfunction

    function automatic logic [CHAR_W-1:0] with_meta(input logic [CHAR_W-1:0] v, input logic m);
        return m ? (v | META_BIT) : v;
    endfunction

    assign dig     = digit_of(in_char);
    assign dec_sum = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + {9'd0, dig};
    assign ds_inc  = ds_reg + 2'd1;

    always_comb begin
        dig_ok   = 1'b0;
        acc_sum  = acc_reg;
        dig_full = 1'b0;
        case (phase_reg)
            PH_HEX: begin
                dig_ok   = !dig[4];
                acc_sum  = {acc_reg[ACC_W-5:0], dig[3:0]};
                dig_full = (ds_inc >= 2'd2);
            end
            PH_OCT: begin
                dig_ok   = (dig < 5'd8);
                acc_sum  = {acc_reg[ACC_W-4:0], dig[2:0]};
                dig_full = (ds_inc >= 2'd3);
            end
            PH_DEC: begin
                dig_ok   = (dig < 5'd10);
                acc_sum  = dec_sum[ACC_W-1:0];
                dig_full = (ds_inc >= 2'd3);
            end
            default: begin
                dig_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        case (in_char)
            8'h6e:   esc_val = 8'd10;
            8'h74:   esc_val = 8'd9;
            8'h62:   esc_val = 8'd8;
            8'h72:   esc_val = 8'd13;
            default: esc_val = in_char;
        endcase
    end

    always_comb begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        ds_next    = ds_reg;
        meta_next  = meta_reg;
        push_rec   = '0;

        case (phase_reg)
            PH_BSL: begin
                if (!meta_reg && (in_char == 8'h6d || in_char == 8'h4d)) begin
                    meta_next  = 1'b1;
                    phase_next = PH_IDLE;
                end else if (in_char >= CH_ZERO && in_char <= 8'h39) begin
                    phase_next = PH_DEC;
                    acc_next   = ACC_W'(in_char - CH_ZERO);
                    ds_next    = 2'd1;
                end else if (in_char == 8'h78 || in_char == 8'h58) begin
                    phase_next = PH_HEX;
                    acc_next   = '0;
                    ds_next    = '0;
                end else if (in_char == 8'h6f || in_char == 8'h4f) begin
                    phase_next = PH_OCT;
                    acc_next   = '0;
                    ds_next    = '0;
                end else begin
                    push_rec.cnt = 2'd1;
                    push_rec.ch0 = with_meta(esc_val, meta_reg);
                    phase_next   = PH_IDLE;
                    acc_next     = '0;
                    ds_next      = '0;
                    meta_next    = 1'b0;
                end
            end
            PH_CARET: begin
                push_rec.cnt = 2'd1;
                push_rec.ch0 = with_meta(in_char & CTRL_MASK, meta_reg);
                phase_next   = PH_IDLE;
                acc_next     = '0;
                ds_next      = '0;
                meta_next    = 1'b0;
            end
            PH_HEX, PH_OCT, PH_DEC: begin
                if (dig_ok) begin
                    acc_next = acc_sum;
                    ds_next  = ds_inc;
                    if (dig_full) begin
                        push_rec.cnt = 2'd1;
                        push_rec.ch0 = with_meta(acc_sum[CHAR_W-1:0], meta_reg);
                        phase_next   = PH_IDLE;
                        acc_next     = '0;
                        ds_next      = '0;
                        meta_next    = 1'b0;
                    end
                end else begin
                    // close the number, then decode the non-digit afresh
                    push_rec.cnt = 2'd1;
                    push_rec.ch0 = with_meta(acc_reg[CHAR_W-1:0], meta_reg);
                    acc_next     = '0;
                    ds_next      = '0;
                    meta_next    = 1'b0;
                    if (in_char == CH_BSL) begin
                        phase_next = PH_BSL;
                    end else if (in_char == CH_CARET) begin
                        phase_next = PH_CARET;
                    end else begin
                        push_rec.cnt = 2'd2;
                        push_rec.ch1 = in_char;
                        phase_next   = PH_IDLE;
                    end
                end
            end
            default: begin
                if (in_char == CH_BSL) begin
                    phase_next = PH_BSL;
                end else if (in_char == CH_CARET) begin
                    phase_next = PH_CARET;
                end else begin
                    push_rec.cnt = 2'd1;
                    push_rec.ch0 = with_meta(in_char, meta_reg);
                    phase_next   = PH_IDLE;
                    acc_next     = '0;
                    ds_next      = '0;
                    meta_next    = 1'b0;
                end
            end
        endcase

        numeric_next = (phase_next == PH_HEX) || (phase_next == PH_OCT) ||
                       (phase_next == PH_DEC);

        // end of string: flush a pending number, drop any open escape
        if (in_last) begin
            if (numeric_next && ds_next != 2'd0) begin
                push_rec.cnt = 2'd1;
                push_rec.ch0 = with_meta(acc_next[CHAR_W-1:0], meta_next);
            end
            push_rec.term = 1'b1;
            phase_next    = PH_IDLE;
            acc_next      = '0;
            ds_next       = '0;
            meta_next     = 1'b0;
        end
    end

    assign push = in_fire && (push_rec.cnt != 2'd0 || push_rec.term);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            acc_reg   <= '0;
            ds_reg    <= '0;
            meta_reg  <= 1'b0;
        end else if (in_fire) begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            ds_reg    <= ds_next;
            meta_reg  <= meta_next;
        end
    end

endmodule

`default_nettype wire

>>> src/ecd_queue.sv
// Record queue between the decoding front end and the output serializer.
`timescale 1ns / 1ps
`default_nettype none

module ecd_queue #(
    parameter int DEPTH = ecd_pkg::QUEUE_DEPTH
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         push,
    input  wire ecd_pkg::rec_t                push_rec,
    input  wire logic                         pop,
    output logic                              head_valid,
    output ecd_pkg::rec_t                     head_rec,
    output logic                              full,
    output logic [$clog2(DEPTH+1)-1:0]        level
);
    import ecd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH+1);

    rec_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == LVL_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_rec   = mem_reg[rd_ptr_reg];
    assign level      = count_reg;
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + LVL_W'(1);
            2'b01:   count_next = count_reg - LVL_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

`default_nettype wire

>>> src/ecd_back.sv
// Back end: splits each record into output words and drives the output register.
`timescale 1ns / 1ps
`default_nettype none

module ecd_back (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       head_valid,
    input  wire ecd_pkg::rec_t              head_rec,
    output logic                            pop,
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic [ecd_pkg::CHAR_W-1:0]      m_axis_tdata,
    output logic                            m_axis_tlast
);
    import ecd_pkg::*;

    logic [1:0]        idx_reg, idx_next;
    logic              tvalid_reg, tvalid_next;
    logic [CHAR_W-1:0] tdata_reg, tdata_next;
    logic              tlast_reg, tlast_next;
    logic [1:0]        words;
    logic              last_word;
    logic              load;
    logic [CHAR_W-1:0] sel_char;
    logic              sel_end;

    assign words     = head_rec.cnt + {1'b0, head_rec.term};
    assign last_word = (idx_reg == words - 2'd1);
    assign load      = head_valid && (!tvalid_reg || m_axis_tready);
    assign pop       = load && last_word;

    // bytes first, terminator last
    always_comb begin
        if (idx_reg < head_rec.cnt) begin
            sel_char = (idx_reg == 2'd0) ? head_rec.ch0 : head_rec.ch1;
            sel_end  = 1'b0;
        end else begin
            sel_char = '0;
            sel_end  = 1'b1;
        end
    end

    always_comb begin
        idx_next    = idx_reg;
        tvalid_next = tvalid_reg;
        tdata_next  = tdata_reg;
        tlast_next  = tlast_reg;
        if (load) begin
            idx_next    = last_word ? 2'd0 : idx_reg + 2'd1;
            tvalid_next = 1'b1;
            tdata_next  = sel_char;
            tlast_next  = sel_end;
        end else if (m_axis_tready) begin
            tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg    <= '0;
            tvalid_reg <= 1'b0;
        end else begin
            idx_reg    <= idx_next;
            tvalid_reg <= tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tdata_reg <= tdata_next;
        tlast_reg <= tlast_next;
    end

    assign m_axis_tvalid = tvalid_reg;
    assign m_axis_tdata  = tdata_reg;
    assign m_axis_tlast  = tlast_reg;

endmodule

`default_nettype wire
